FILE: rtl/core/ucd_pkg.sv
// Shared constants, widths and types for the Unix time to calendar date converter.
// No dependencies; every other file in rtl/core refers to this package by scoped name.
`default_nettype none

package ucd_pkg;

   localparam int SECONDS_WIDTH = 32;
   localparam int REQ_DATA_W    = ((SECONDS_WIDTH + 7) / 8) * 8;

   localparam int DAY_W    = 5;
   localparam int MONTH_W  = 4;
   localparam int YEAR_W   = 12;
   localparam int HOUR_W   = 5;
   localparam int MINUTE_W = 6;
   localparam int SECOND_W = 6;

   localparam int RSP_FIELDS_W = DAY_W + MONTH_W + YEAR_W + HOUR_W + MINUTE_W + SECOND_W;
   localparam int RSP_DATA_W   = ((RSP_FIELDS_W + 7) / 8) * 8;

   localparam int NUM_STAGES = 13;
   typedef logic [NUM_STAGES-1:0] stage_mask_type;

   // seconds -> days and time of day: 86400 = 128 * 675
   localparam int              PRESHIFT        = 7;
   localparam int              SHIFTED_W       = SECONDS_WIDTH - PRESHIFT;
   localparam longint unsigned DAY_DIV         = 64'd675;
   localparam int              DAY_RECIP_SHIFT = SECONDS_WIDTH;
   localparam int              DAY_RECIP_W     = SECONDS_WIDTH - 9;
   localparam longint unsigned DAY_RECIP       = (64'd1 << SECONDS_WIDTH) / DAY_DIV;
   localparam int              DAYS_W          = SECONDS_WIDTH - 16;
   localparam int              DAY_RAW_W       = 11;
   localparam int              DAY_REM_W       = 10;
   localparam int              TOD_W           = 17;

   // days -> civil date, counted from 0000-03-01
   localparam longint unsigned SHIFT_DAYS = 64'd719468;
   localparam longint unsigned ERA_DAYS   = 64'd146097;
   localparam int Z_W     = $clog2((64'd1 << DAYS_W) + SHIFT_DAYS);
   localparam int MAX_ERA = int'(((64'd1 << DAYS_W) - 64'd1 + SHIFT_DAYS) / ERA_DAYS);
   localparam int ERA_W   = $clog2(MAX_ERA + 1);

   localparam int              DOE_W           = 18;
   localparam longint unsigned QUAD_DAYS       = 64'd1460;
   localparam longint unsigned CENTURY_DAYS    = 64'd36524;
   localparam longint unsigned LAST_DOE        = 64'd146096;
   localparam int              NUM_CENTURIES   = 4;
   localparam int              RECIP_SHIFT     = 20;
   localparam longint unsigned QUAD_RECIP      = (64'd1 << RECIP_SHIFT) / QUAD_DAYS;
   localparam int              QUAD_RECIP_W    = 10;
   localparam int              QUAD_W          = 7;
   localparam int              CENT_W          = 3;
   localparam longint unsigned YEAR_DAYS       = 64'd365;
   localparam longint unsigned YEAR_RECIP      = (64'd1 << RECIP_SHIFT) / YEAR_DAYS;
   localparam int              YEAR_RECIP_W    = 12;
   localparam int              YOE_W           = 9;
   localparam int              DOY_W           = 9;
   localparam int              ERA_YEARS       = 400;
   localparam int              CIVIL_YEAR_W    = $clog2(MAX_ERA * ERA_YEARS + ERA_YEARS + 1);

   // March-based month index at which the calendar year rolls over
   localparam int MONTHS         = 12;
   localparam int MP_W           = 4;
   localparam int JANUARY_MP     = 10;
   localparam int MARCH_OFFSET   = 3;
   localparam int JANUARY_OFFSET = 9;

   // first day of each March-based month within the shifted year
   localparam logic [MONTHS-1:0][DOY_W-1:0] MONTH_START = {
      9'd337, 9'd306, 9'd275, 9'd245, 9'd214, 9'd184,
      9'd153, 9'd122, 9'd92,  9'd61,  9'd31,  9'd0
   };

   // time of day -> hour, minute, second: 3600 = 16 * 225, 60 = 4 * 15
   localparam int              HOUR_PRESHIFT  = 4;
   localparam int              HOUR_IN_W      = TOD_W - HOUR_PRESHIFT;
   localparam longint unsigned HOUR_DIV       = 64'd225;
   localparam int              HOUR_SHIFT     = 16;
   localparam longint unsigned HOUR_RECIP     = (64'd1 << HOUR_SHIFT) / HOUR_DIV;
   localparam int              HOUR_RECIP_W   = 9;
   localparam longint unsigned SECS_PER_HOUR  = 64'd3600;
   localparam int              REMH_W         = 12;
   localparam int              MIN_PRESHIFT   = 2;
   localparam int              MIN_IN_W       = REMH_W - MIN_PRESHIFT;
   localparam longint unsigned MIN_DIV        = 64'd15;
   localparam int              MIN_SHIFT      = 12;
   localparam longint unsigned MIN_RECIP      = (64'd1 << MIN_SHIFT) / MIN_DIV;
   localparam int              MIN_RECIP_W    = 9;
   localparam longint unsigned SECS_PER_MIN   = 64'd60;

endpackage

`default_nettype wire

FILE: rtl/core/ucd_split.sv
// Stages 0 to 3: capture the seconds count and split it into whole days and time of day.
// Depends on ucd_pkg.
`default_nettype none

module ucd_split (
   input  wire logic                                 clock,
   input  wire ucd_pkg::stage_mask_type              advance,
   input  wire logic [ucd_pkg::SECONDS_WIDTH-1:0]    secs,
   output logic      [ucd_pkg::DAYS_W-1:0]           days,
   output logic      [ucd_pkg::TOD_W-1:0]            tod
);

   localparam int PROD_W = ucd_pkg::SHIFTED_W + ucd_pkg::DAY_RECIP_W;

   logic [ucd_pkg::SECONDS_WIDTH-1:0] secs_ff;

   logic [PROD_W-1:0]                 prod_in;
   logic [ucd_pkg::DAYS_W-1:0]        est1_ff;
   logic [ucd_pkg::SHIFTED_W-1:0]     x1_ff;
   logic [ucd_pkg::PRESHIFT-1:0]      low1_ff;

   logic [ucd_pkg::SHIFTED_W-1:0]     back_in;
   logic [ucd_pkg::SHIFTED_W-1:0]     raw_in;
   logic [ucd_pkg::DAY_RAW_W-1:0]     raw2_ff;
   logic [ucd_pkg::DAYS_W-1:0]        est2_ff;
   logic [ucd_pkg::PRESHIFT-1:0]      low2_ff;

   logic                              over_in;
   logic [ucd_pkg::DAY_RAW_W-1:0]     rem_in;
   logic [ucd_pkg::DAYS_W-1:0]        days_ff;
   logic [ucd_pkg::TOD_W-1:0]         tod_ff;

   always_ff @(posedge clock) begin
      if (advance[0]) begin
         secs_ff <= secs;
      end
   end

   assign prod_in = PROD_W'(secs_ff[ucd_pkg::SECONDS_WIDTH-1:ucd_pkg::PRESHIFT])
                  * PROD_W'(ucd_pkg::DAY_RECIP);

   always_ff @(posedge clock) begin
      if (advance[1]) begin
         est1_ff <= prod_in[ucd_pkg::DAY_RECIP_SHIFT +: ucd_pkg::DAYS_W];
         x1_ff   <= secs_ff[ucd_pkg::SECONDS_WIDTH-1:ucd_pkg::PRESHIFT];
         low1_ff <= secs_ff[ucd_pkg::PRESHIFT-1:0];
      end
   end

   assign back_in = ucd_pkg::SHIFTED_W'(est1_ff) * ucd_pkg::SHIFTED_W'(ucd_pkg::DAY_DIV);
   assign raw_in  = x1_ff - back_in;

   always_ff @(posedge clock) begin
      if (advance[2]) begin
         raw2_ff <= raw_in[ucd_pkg::DAY_RAW_W-1:0];
         est2_ff <= est1_ff;
         low2_ff <= low1_ff;
      end
   end

   assign over_in = raw2_ff >= ucd_pkg::DAY_RAW_W'(ucd_pkg::DAY_DIV);
   assign rem_in  = over_in ? raw2_ff - ucd_pkg::DAY_RAW_W'(ucd_pkg::DAY_DIV) : raw2_ff;

   always_ff @(posedge clock) begin
      if (advance[3]) begin
         days_ff <= est2_ff + ucd_pkg::DAYS_W'(over_in);
         tod_ff  <= {rem_in[ucd_pkg::DAY_REM_W-1:0], low2_ff};
      end
   end

   assign days = days_ff;
   assign tod  = tod_ff;

endmodule

`default_nettype wire

FILE: rtl/core/ucd_tod.sv
// Stages 4 to 12: split the time of day into hour, minute and second.
// Depends on ucd_pkg.
`default_nettype none

module ucd_tod (
   input  wire logic                             clock,
   input  wire ucd_pkg::stage_mask_type          advance,
   input  wire logic [ucd_pkg::TOD_W-1:0]        tod,
   output logic      [ucd_pkg::HOUR_W-1:0]       hour_of_day,
   output logic      [ucd_pkg::MINUTE_W-1:0]     minute_of_hour,
   output logic      [ucd_pkg::SECOND_W-1:0]     second_of_minute
);

   localparam int HPROD_W  = ucd_pkg::HOUR_IN_W + ucd_pkg::HOUR_RECIP_W;
   localparam int HBOUND_W = ucd_pkg::HOUR_IN_W + 1;
   localparam int MPROD_W  = ucd_pkg::MIN_IN_W + ucd_pkg::MIN_RECIP_W;
   localparam int MBOUND_W = ucd_pkg::MIN_IN_W + 1;

   logic [HPROD_W-1:0]               hprod_in;
   logic [ucd_pkg::HOUR_W-1:0]       he4_ff;
   logic [ucd_pkg::TOD_W-1:0]        tod4_ff;

   logic [HBOUND_W-1:0]              hbound_in;
   logic [ucd_pkg::HOUR_W-1:0]       hour5_ff;
   logic [ucd_pkg::TOD_W-1:0]        tod5_ff;

   logic [ucd_pkg::TOD_W-1:0]        hsecs_in;
   logic [ucd_pkg::TOD_W-1:0]        remh_in;
   logic [ucd_pkg::REMH_W-1:0]       remh6_ff;
   logic [ucd_pkg::HOUR_W-1:0]       hour6_ff;

   logic [MPROD_W-1:0]               mprod_in;
   logic [ucd_pkg::MINUTE_W-1:0]     me7_ff;
   logic [ucd_pkg::REMH_W-1:0]       remh7_ff;
   logic [ucd_pkg::HOUR_W-1:0]       hour7_ff;

   logic [MBOUND_W-1:0]              mbound_in;
   logic [ucd_pkg::MINUTE_W-1:0]     min8_ff;
   logic [ucd_pkg::REMH_W-1:0]       remh8_ff;
   logic [ucd_pkg::HOUR_W-1:0]       hour8_ff;

   logic [ucd_pkg::REMH_W-1:0]       sec_in;
   logic [ucd_pkg::HOUR_W-1:0]       hour9_ff,  hour10_ff,  hour11_ff,  hour12_ff;
   logic [ucd_pkg::MINUTE_W-1:0]     min9_ff,   min10_ff,   min11_ff,   min12_ff;
   logic [ucd_pkg::SECOND_W-1:0]     sec9_ff,   sec10_ff,   sec11_ff,   sec12_ff;

   assign hprod_in = HPROD_W'(tod[ucd_pkg::TOD_W-1:ucd_pkg::HOUR_PRESHIFT])
                   * HPROD_W'(ucd_pkg::HOUR_RECIP);

   always_ff @(posedge clock) begin
      if (advance[4]) begin
         he4_ff  <= hprod_in[ucd_pkg::HOUR_SHIFT +: ucd_pkg::HOUR_W];
         tod4_ff <= tod;
      end
   end

   assign hbound_in = HBOUND_W'(he4_ff + ucd_pkg::HOUR_W'(1)) * HBOUND_W'(ucd_pkg::HOUR_DIV);

   always_ff @(posedge clock) begin
      if (advance[5]) begin
         hour5_ff <= he4_ff + ucd_pkg::HOUR_W'(
            HBOUND_W'(tod4_ff[ucd_pkg::TOD_W-1:ucd_pkg::HOUR_PRESHIFT]) >= hbound_in);
         tod5_ff  <= tod4_ff;
      end
   end

   assign hsecs_in = ucd_pkg::TOD_W'(hour5_ff) * ucd_pkg::TOD_W'(ucd_pkg::SECS_PER_HOUR);
   assign remh_in  = tod5_ff - hsecs_in;

   always_ff @(posedge clock) begin
      if (advance[6]) begin
         remh6_ff <= remh_in[ucd_pkg::REMH_W-1:0];
         hour6_ff <= hour5_ff;
      end
   end

   assign mprod_in = MPROD_W'(remh6_ff[ucd_pkg::REMH_W-1:ucd_pkg::MIN_PRESHIFT])
                   * MPROD_W'(ucd_pkg::MIN_RECIP);

   always_ff @(posedge clock) begin
      if (advance[7]) begin
         me7_ff   <= mprod_in[ucd_pkg::MIN_SHIFT +: ucd_pkg::MINUTE_W];
         remh7_ff <= remh6_ff;
         hour7_ff <= hour6_ff;
      end
   end

   assign mbound_in = MBOUND_W'(me7_ff + ucd_pkg::MINUTE_W'(1)) * MBOUND_W'(ucd_pkg::MIN_DIV);

   always_ff @(posedge clock) begin
      if (advance[8]) begin
         min8_ff  <= me7_ff + ucd_pkg::MINUTE_W'(
            MBOUND_W'(remh7_ff[ucd_pkg::REMH_W-1:ucd_pkg::MIN_PRESHIFT]) >= mbound_in);
         remh8_ff <= remh7_ff;
         hour8_ff <= hour7_ff;
      end
   end

   assign sec_in = remh8_ff
                 - ucd_pkg::REMH_W'(min8_ff) * ucd_pkg::REMH_W'(ucd_pkg::SECS_PER_MIN);

   always_ff @(posedge clock) begin
      if (advance[9]) begin
         hour9_ff <= hour8_ff;
         min9_ff  <= min8_ff;
         sec9_ff  <= sec_in[ucd_pkg::SECOND_W-1:0];
      end
      if (advance[10]) begin
         hour10_ff <= hour9_ff;
         min10_ff  <= min9_ff;
         sec10_ff  <= sec9_ff;
      end
      if (advance[11]) begin
         hour11_ff <= hour10_ff;
         min11_ff  <= min10_ff;
         sec11_ff  <= sec10_ff;
      end
      if (advance[12]) begin
         hour12_ff <= hour11_ff;
         min12_ff  <= min11_ff;
         sec12_ff  <= sec11_ff;
      end
   end

   assign hour_of_day      = hour12_ff;
   assign minute_of_hour   = min12_ff;
   assign second_of_minute = sec12_ff;

endmodule

`default_nettype wire

FILE: rtl/core/ucd_date.sv
// Stages 4 to 12: convert whole days since the epoch into day, month and Gregorian year.
// Depends on ucd_pkg.
`default_nettype none

module ucd_date (
   input  wire logic                             clock,
   input  wire ucd_pkg::stage_mask_type          advance,
   input  wire logic [ucd_pkg::DAYS_W-1:0]       days,
   output logic      [ucd_pkg::DAY_W-1:0]        day_of_month,
   output logic      [ucd_pkg::MONTH_W-1:0]      month_number,
   output logic      [ucd_pkg::YEAR_W-1:0]       year_number
);

   localparam int QPROD_W  = ucd_pkg::DOE_W + ucd_pkg::QUAD_RECIP_W;
   localparam int YPROD_W  = ucd_pkg::DOE_W + ucd_pkg::YEAR_RECIP_W;
   localparam int BOUND_W  = ucd_pkg::DOE_W + 1;
   localparam int HUND_W   = 2;

   // stage 4
   logic [ucd_pkg::Z_W-1:0]          z_in;
   logic [ucd_pkg::ERA_W-1:0]        era_in;
   logic [ucd_pkg::Z_W-1:0]          z4_ff;
   logic [ucd_pkg::ERA_W-1:0]        era4_ff;
   // stage 5
   logic [ucd_pkg::Z_W-1:0]          off_in;
   logic [ucd_pkg::Z_W-1:0]          doe_in;
   logic [ucd_pkg::DOE_W-1:0]        doe5_ff;
   logic [ucd_pkg::ERA_W-1:0]        era5_ff;
   // stage 6
   logic [QPROD_W-1:0]               qprod_in;
   logic [ucd_pkg::CENT_W-1:0]       cent_in;
   logic [ucd_pkg::QUAD_W-1:0]       qest6_ff;
   logic [ucd_pkg::CENT_W-1:0]       cent6_ff;
   logic                             last6_ff;
   logic [ucd_pkg::DOE_W-1:0]        doe6_ff;
   logic [ucd_pkg::ERA_W-1:0]        era6_ff;
   // stage 7
   logic [BOUND_W-1:0]               qbound_in;
   logic [ucd_pkg::QUAD_W-1:0]       quad7_ff;
   logic [ucd_pkg::CENT_W-1:0]       cent7_ff;
   logic                             last7_ff;
   logic [ucd_pkg::DOE_W-1:0]        doe7_ff;
   logic [ucd_pkg::ERA_W-1:0]        era7_ff;
   // stage 8
   logic [ucd_pkg::DOE_W-1:0]        n_in;
   logic [ucd_pkg::DOE_W-1:0]        n8_ff;
   logic [ucd_pkg::DOE_W-1:0]        doe8_ff;
   logic [ucd_pkg::ERA_W-1:0]        era8_ff;
   // stage 9
   logic [YPROD_W-1:0]               yprod_in;
   logic [ucd_pkg::YOE_W-1:0]        yest9_ff;
   logic [ucd_pkg::DOE_W-1:0]        n9_ff;
   logic [ucd_pkg::DOE_W-1:0]        doe9_ff;
   logic [ucd_pkg::ERA_W-1:0]        era9_ff;
   // stage 10
   logic [BOUND_W-1:0]               ybound_in;
   logic [ucd_pkg::YOE_W-1:0]        yoe10_ff;
   logic [ucd_pkg::DOE_W-1:0]        doe10_ff;
   logic [ucd_pkg::ERA_W-1:0]        era10_ff;
   // stage 11
   logic [HUND_W-1:0]                hund_in;
   logic [ucd_pkg::DOE_W-1:0]        base_in;
   logic [ucd_pkg::DOE_W-1:0]        doy_in;
   logic [ucd_pkg::DOY_W-1:0]        doy11_ff;
   logic [ucd_pkg::CIVIL_YEAR_W-1:0] yc11_ff;
   // stage 12
   logic [ucd_pkg::MP_W-1:0]         mp_in;
   logic [ucd_pkg::DOY_W-1:0]        start_in;
   logic [ucd_pkg::DOY_W-1:0]        dom_in;
   logic                             next_year_in;
   logic [ucd_pkg::MP_W-1:0]         month_in;
   logic [ucd_pkg::CIVIL_YEAR_W-1:0] year_in;
   logic [ucd_pkg::DAY_W-1:0]        day12_ff;
   logic [ucd_pkg::MONTH_W-1:0]      month12_ff;
   logic [ucd_pkg::YEAR_W-1:0]       year12_ff;

   always_comb begin
      z_in   = ucd_pkg::Z_W'(days) + ucd_pkg::Z_W'(ucd_pkg::SHIFT_DAYS);
      era_in = '0;
      for (int k = 1; k <= ucd_pkg::MAX_ERA; k++) begin
         if (z_in >= ucd_pkg::Z_W'(longint'(k) * ucd_pkg::ERA_DAYS)) begin
            era_in = era_in + ucd_pkg::ERA_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance[4]) begin
         z4_ff   <= z_in;
         era4_ff <= era_in;
      end
   end

   assign off_in = ucd_pkg::Z_W'(era4_ff) * ucd_pkg::Z_W'(ucd_pkg::ERA_DAYS);
   assign doe_in = z4_ff - off_in;

   always_ff @(posedge clock) begin
      if (advance[5]) begin
         doe5_ff <= doe_in[ucd_pkg::DOE_W-1:0];
         era5_ff <= era4_ff;
      end
   end

   assign qprod_in = QPROD_W'(doe5_ff) * QPROD_W'(ucd_pkg::QUAD_RECIP);

   always_comb begin
      cent_in = '0;
      for (int k = 1; k <= ucd_pkg::NUM_CENTURIES; k++) begin
         if (doe5_ff >= ucd_pkg::DOE_W'(longint'(k) * ucd_pkg::CENTURY_DAYS)) begin
            cent_in = cent_in + ucd_pkg::CENT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance[6]) begin
         qest6_ff <= qprod_in[ucd_pkg::RECIP_SHIFT +: ucd_pkg::QUAD_W];
         cent6_ff <= cent_in;
         last6_ff <= doe5_ff >= ucd_pkg::DOE_W'(ucd_pkg::LAST_DOE);
         doe6_ff  <= doe5_ff;
         era6_ff  <= era5_ff;
      end
   end

   assign qbound_in = BOUND_W'(qest6_ff + ucd_pkg::QUAD_W'(1)) * BOUND_W'(ucd_pkg::QUAD_DAYS);

   always_ff @(posedge clock) begin
      if (advance[7]) begin
         quad7_ff <= qest6_ff + ucd_pkg::QUAD_W'(BOUND_W'(doe6_ff) >= qbound_in);
         cent7_ff <= cent6_ff;
         last7_ff <= last6_ff;
         doe7_ff  <= doe6_ff;
         era7_ff  <= era6_ff;
      end
   end

   assign n_in = doe7_ff - ucd_pkg::DOE_W'(quad7_ff) + ucd_pkg::DOE_W'(cent7_ff)
               - ucd_pkg::DOE_W'(last7_ff);

   always_ff @(posedge clock) begin
      if (advance[8]) begin
         n8_ff   <= n_in;
         doe8_ff <= doe7_ff;
         era8_ff <= era7_ff;
      end
   end

   assign yprod_in = YPROD_W'(n8_ff) * YPROD_W'(ucd_pkg::YEAR_RECIP);

   always_ff @(posedge clock) begin
      if (advance[9]) begin
         yest9_ff <= yprod_in[ucd_pkg::RECIP_SHIFT +: ucd_pkg::YOE_W];
         n9_ff    <= n8_ff;
         doe9_ff  <= doe8_ff;
         era9_ff  <= era8_ff;
      end
   end

   assign ybound_in = BOUND_W'(yest9_ff + ucd_pkg::YOE_W'(1)) * BOUND_W'(ucd_pkg::YEAR_DAYS);

   always_ff @(posedge clock) begin
      if (advance[10]) begin
         yoe10_ff <= yest9_ff + ucd_pkg::YOE_W'(BOUND_W'(n9_ff) >= ybound_in);
         doe10_ff <= doe9_ff;
         era10_ff <= era9_ff;
      end
   end

   always_comb begin
      hund_in = '0;
      for (int k = 1; k < ucd_pkg::NUM_CENTURIES; k++) begin
         if (yoe10_ff >= ucd_pkg::YOE_W'(k * 100)) begin
            hund_in = hund_in + HUND_W'(1);
         end
      end
      base_in = ucd_pkg::DOE_W'(yoe10_ff) * ucd_pkg::DOE_W'(ucd_pkg::YEAR_DAYS)
              + ucd_pkg::DOE_W'(yoe10_ff[ucd_pkg::YOE_W-1:2])
              - ucd_pkg::DOE_W'(hund_in);
      doy_in  = doe10_ff - base_in;
   end

   always_ff @(posedge clock) begin
      if (advance[11]) begin
         doy11_ff <= doy_in[ucd_pkg::DOY_W-1:0];
         yc11_ff  <= ucd_pkg::CIVIL_YEAR_W'(era10_ff) * ucd_pkg::CIVIL_YEAR_W'(ucd_pkg::ERA_YEARS)
                   + ucd_pkg::CIVIL_YEAR_W'(yoe10_ff);
      end
   end

   always_comb begin
      mp_in = '0;
      for (int k = 1; k < ucd_pkg::MONTHS; k++) begin
         if (doy11_ff >= ucd_pkg::MONTH_START[k]) begin
            mp_in = mp_in + ucd_pkg::MP_W'(1);
         end
      end
      start_in     = ucd_pkg::MONTH_START[mp_in];
      dom_in       = doy11_ff - start_in + ucd_pkg::DOY_W'(1);
      next_year_in = mp_in >= ucd_pkg::MP_W'(ucd_pkg::JANUARY_MP);
      month_in     = next_year_in ? mp_in - ucd_pkg::MP_W'(ucd_pkg::JANUARY_OFFSET)
                                  : mp_in + ucd_pkg::MP_W'(ucd_pkg::MARCH_OFFSET);
      year_in      = yc11_ff + ucd_pkg::CIVIL_YEAR_W'(next_year_in);
   end

   always_ff @(posedge clock) begin
      if (advance[12]) begin
         day12_ff   <= dom_in[ucd_pkg::DAY_W-1:0];
         month12_ff <= month_in[ucd_pkg::MONTH_W-1:0];
         year12_ff  <= year_in[ucd_pkg::YEAR_W-1:0];
      end
   end

   assign day_of_month = day12_ff;
   assign month_number = month12_ff;
   assign year_number  = year12_ff;

endmodule

`default_nettype wire

FILE: rtl/core/unix_time_to_calendar_date.sv
// Unix seconds to calendar date and time of day; uses ucd_pkg, ucd_split, ucd_tod, ucd_date.
// Throughput: one transaction per cycle, set by the 13-stage pipeline with per-stage valids,
// unless every stage is full while rsp_tready is low.
// A stalled output holds only the full stages with no empty stage ahead; empty stages keep filling.
// Reset (synchronous, active high) clears every stage valid; payload registers are not reset.
`default_nettype none

module unix_time_to_calendar_date (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_tvalid,
   output logic                                    req_tready,
   input  wire logic [ucd_pkg::REQ_DATA_W-1:0]     req_tdata,   // [31:0] unix_seconds
   output logic                                    rsp_tvalid,
   input  wire logic                               rsp_tready,
   // [4:0] day_of_month, [8:5] month_number, [20:9] year_number, [25:21] hour_of_day,
   // [31:26] minute_of_hour, [37:32] second_of_minute, [39:38] zero
   output logic      [ucd_pkg::RSP_DATA_W-1:0]     rsp_tdata
);

   localparam int LAST  = ucd_pkg::NUM_STAGES - 1;
   localparam int PAD_W = ucd_pkg::RSP_DATA_W - ucd_pkg::RSP_FIELDS_W;

   ucd_pkg::stage_mask_type valid_ff;
   ucd_pkg::stage_mask_type valid_in;
   ucd_pkg::stage_mask_type shifted_in;
   ucd_pkg::stage_mask_type advance;

   logic [ucd_pkg::DAYS_W-1:0]   days;
   logic [ucd_pkg::TOD_W-1:0]    tod;
   logic [ucd_pkg::DAY_W-1:0]    day_of_month;
   logic [ucd_pkg::MONTH_W-1:0]  month_number;
   logic [ucd_pkg::YEAR_W-1:0]   year_number;
   logic [ucd_pkg::HOUR_W-1:0]   hour_of_day;
   logic [ucd_pkg::MINUTE_W-1:0] minute_of_hour;
   logic [ucd_pkg::SECOND_W-1:0] second_of_minute;

   // a stage may load when it or any stage ahead of it is empty, or the output drains
   always_comb begin
      for (int k = 0; k <= LAST; k++) begin
         advance[k] = rsp_tready || ((~valid_ff >> k) != '0);
      end
      shifted_in = {valid_ff[LAST-1:0], req_tvalid};
      valid_in   = (advance & shifted_in) | (~advance & valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign req_tready = advance[0];
   assign rsp_tvalid = valid_ff[LAST];

   ucd_split u_split (
      .clock   (clock),
      .advance (advance),
      .secs    (req_tdata[ucd_pkg::SECONDS_WIDTH-1:0]),
      .days    (days),
      .tod     (tod)
   );

   ucd_tod u_tod (
      .clock            (clock),
      .advance          (advance),
      .tod              (tod),
      .hour_of_day      (hour_of_day),
      .minute_of_hour   (minute_of_hour),
      .second_of_minute (second_of_minute)
   );

   ucd_date u_date (
      .clock        (clock),
      .advance      (advance),
      .days         (days),
      .day_of_month (day_of_month),
      .month_number (month_number),
      .year_number  (year_number)
   );

   assign rsp_tdata = {{PAD_W{1'b0}}, second_of_minute, minute_of_hour, hour_of_day,
                       year_number, month_number, day_of_month};

endmodule

`default_nettype wire

FILE: rtl/core/ucd_checker.sv
// Port-level checks for unix_time_to_calendar_date, attached to the top level by bind.
// Depends on ucd_pkg.
`default_nettype none

module ucd_checker (
   input wire logic                             clock,
   input wire logic                             reset,
   input wire logic                             req_tvalid,
   input wire logic                             req_tready,
   input wire logic [ucd_pkg::REQ_DATA_W-1:0]   req_tdata,
   input wire logic                             rsp_tvalid,
   input wire logic                             rsp_tready,
   input wire logic [ucd_pkg::RSP_DATA_W-1:0]   rsp_tdata
);

   localparam int CNT_W = $clog2(ucd_pkg::NUM_STAGES + 1);

   logic [CNT_W-1:0] pending_ff;
   logic [CNT_W-1:0] pending_in;
   logic             req_xfer;
   logic             rsp_xfer;
   logic [4:0]       day;
   logic [3:0]       month;
   logic [4:0]       hour;
   logic [5:0]       minute;
   logic [5:0]       second;

   assign req_xfer = req_tvalid && req_tready;
   assign rsp_xfer = rsp_tvalid && rsp_tready;
   assign day      = rsp_tdata[4:0];
   assign month    = rsp_tdata[8:5];
   assign hour     = rsp_tdata[25:21];
   assign minute   = rsp_tdata[31:26];
   assign second   = rsp_tdata[37:32];

   assign pending_in = pending_ff + CNT_W'(req_xfer) - CNT_W'(rsp_xfer);

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("rsp_tvalid high right after reset");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled response transaction changed or dropped");

   assert property (@(posedge clock) disable iff (reset)
      (!rsp_tvalid || pending_ff != '0) && pending_ff <= CNT_W'(ucd_pkg::NUM_STAGES))
      else $error("response without request or too many transactions in flight");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> day >= 5'd1 && month >= 4'd1 && month <= 4'd12
                     && hour <= 5'd23 && minute <= 6'd59 && second <= 6'd59
                     && rsp_tdata[ucd_pkg::RSP_DATA_W-1:ucd_pkg::RSP_FIELDS_W] == '0)
      else $error("response field out of range");

   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && !req_tready |=> req_tvalid && $stable(req_tdata))
      else $error("stalled request transaction changed or dropped");

endmodule

bind unix_time_to_calendar_date ucd_checker u_checker (.*);

`default_nettype wire
